// ----- src/eplff_pkg.sv -----
package eplff_pkg;

  localparam int BYTES_PER_LINE_DEF = 25;
  localparam int LINE_COUNT_DEF     = 96;

  localparam int LINE_W    = 7;
  localparam int SCAN_AT_W = LINE_W - 2;

  // SPI framing and panel register codes
  localparam logic [7:0] CMD_INDEX   = 8'h70;
  localparam logic [7:0] CMD_DATA    = 8'h72;
  localparam logic [7:0] REG_CTRL    = 8'h04;
  localparam logic [7:0] VAL_CTRL    = 8'h02;
  localparam logic [7:0] REG_LINE    = 8'h0A;
  localparam logic [7:0] REG_OUTPUT  = 8'h02;
  localparam logic [7:0] VAL_OUTPUT  = 8'h25;
  localparam logic [7:0] PIX_MASK    = 8'hAA;
  localparam logic [7:0] SCAN_TOP    = 8'hC0;

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    logic [7:0]        pixel_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       frame_start;
    logic       last_pair;
  } out_t;

  // one finished line waiting for the back end
  typedef struct packed {
    logic                 bank;
    logic                 scan_on;
    logic [SCAN_AT_W-1:0] scan_at;
    logic [7:0]           scan_val;
  } job_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef enum logic [1:0] {
    SEL_LIT,
    SEL_EVEN,
    SEL_ODD
  } byte_sel_t;

  function automatic logic [7:0] bit_rev(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [7:0] odd_form(input logic [7:0] v);
    return ((v & PIX_MASK) >> 1) | PIX_MASK;
  endfunction

  function automatic logic [7:0] even_form(input logic [7:0] v);
    return odd_form(bit_rev(v));
  endfunction

  // 70 04 72 02 70 0A 72
  function automatic logic [7:0] head_byte(input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = CMD_INDEX;
      3'd1:    b = REG_CTRL;
      3'd2:    b = CMD_DATA;
      3'd3:    b = VAL_CTRL;
      3'd4:    b = CMD_INDEX;
      3'd5:    b = REG_LINE;
      default: b = CMD_DATA;
    endcase
    return b;
  endfunction

  // 70 02 72 25
  function automatic logic [7:0] tail_byte(input logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = CMD_INDEX;
      2'd1:    b = REG_OUTPUT;
      2'd2:    b = CMD_DATA;
      default: b = VAL_OUTPUT;
    endcase
    return b;
  endfunction

endpackage

// ----- src/eplff_job_queue.sv -----
module eplff_job_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  eplff_pkg::job_t   push_job,
  input  logic              pop,
  output eplff_pkg::job_t   head,
  output logic              not_empty,
  output logic              full
);

  eplff_pkg::job_t entry [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  assign head      = entry[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

endmodule

// ----- src/eplff_front.sv -----
module eplff_front #(
  parameter int BYTES_PER_LINE = eplff_pkg::BYTES_PER_LINE_DEF,
  parameter int LINE_COUNT     = eplff_pkg::LINE_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  eplff_pkg::in_t                      pixel,
  output logic                                wr_en,
  output logic [$clog2(BYTES_PER_LINE):0]     wr_addr,
  output logic [7:0]                          wr_data,
  output logic                                job_push,
  output eplff_pkg::job_t                     job,
  input  logic                                queue_full,
  input  logic                                done,
  input  logic                                done_bank
);

  localparam int IDX_W = $clog2(BYTES_PER_LINE);

  logic [IDX_W-1:0]             byte_count;
  logic                         wbank;
  logic [1:0]                   held;
  logic [1:0]                   held_next;
  logic                         accept;
  logic                         last_byte;
  logic [eplff_pkg::LINE_W-1:0] line_m1;

  // a bank stays held from the end of its line until the back end has read it out
  assign pixel_stall = held[wbank] | queue_full;
  assign accept      = pixel_valid & ~pixel_stall;
  assign last_byte   = (byte_count == IDX_W'(BYTES_PER_LINE - 1));
  assign job_push    = accept & last_byte;

  assign wr_en   = accept;
  assign wr_addr = {wbank, byte_count};
  assign wr_data = pixel.pixel_byte;

  assign line_m1      = pixel.line_number - eplff_pkg::LINE_W'(1);
  assign job.bank     = wbank;
  assign job.scan_on  = (pixel.line_number != '0) &&
                        (32'(pixel.line_number) <= 32'(LINE_COUNT));
  assign job.scan_at  = line_m1[eplff_pkg::LINE_W-1:2];
  assign job.scan_val = eplff_pkg::SCAN_TOP >> {line_m1[1:0], 1'b0};

  always_comb begin
    held_next = held;
    if (done) begin
      held_next[done_bank] = 1'b0;
    end
    if (job_push) begin
      held_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      wbank      <= 1'b0;
      held       <= 2'b00;
    end else begin
      held <= held_next;
      if (accept) begin
        if (last_byte) begin
          byte_count <= '0;
          wbank      <= ~wbank;
        end else begin
          byte_count <= byte_count + IDX_W'(1);
        end
      end
    end
  end

endmodule

// ----- src/eplff_back.sv -----
module eplff_back #(
  parameter int BYTES_PER_LINE = eplff_pkg::BYTES_PER_LINE_DEF,
  parameter int LINE_COUNT     = eplff_pkg::LINE_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  input  eplff_pkg::job_t                     job,
  output logic                                job_pop,
  input  logic                                wr_en,
  input  logic [$clog2(BYTES_PER_LINE):0]     wr_addr,
  input  logic [7:0]                          wr_data,
  output logic                                done,
  output logic                                done_bank,
  output logic                                pair_valid,
  input  logic                                pair_stall,
  output eplff_pkg::out_t                     pair
);

  localparam int SCANS      = (LINE_COUNT + 3) / 4;
  localparam int EVEN_BASE  = 7;
  localparam int SCAN_BASE  = EVEN_BASE + BYTES_PER_LINE;
  localparam int ODD_BASE   = SCAN_BASE + SCANS;
  localparam int BORDER     = ODD_BASE + BYTES_PER_LINE;
  localparam int NBYTES     = BORDER + 1 + (SCANS % 2) + 4;
  localparam int TAIL_BASE  = NBYTES - 4;
  localparam int PAIRS      = NBYTES / 2;
  localparam int PAIR_W     = $clog2(PAIRS);
  localparam int POS_W      = PAIR_W + 1;
  localparam int IDX_W      = $clog2(BYTES_PER_LINE);
  localparam int ADDR_W     = IDX_W + 1;
  localparam int DEPTH      = 2 ** ADDR_W;

  typedef struct packed {
    eplff_pkg::byte_sel_t sel;
    logic [7:0]           lit;
    logic [IDX_W-1:0]     idx;
  } slot_t;

  function automatic slot_t classify(input logic [POS_W-1:0] pos,
                                     input logic             scan_on,
                                     input logic [POS_W-1:0] scan_pos,
                                     input logic [7:0]       scan_val);
    slot_t s;
    s.sel = eplff_pkg::SEL_LIT;
    s.lit = 8'h00;
    s.idx = '0;
    if (pos < POS_W'(EVEN_BASE)) begin
      s.lit = eplff_pkg::head_byte(3'(pos));
    end else if (pos < POS_W'(SCAN_BASE)) begin
      // even bytes run from the end of the line back to its start
      s.sel = eplff_pkg::SEL_EVEN;
      s.idx = IDX_W'(POS_W'(SCAN_BASE - 1) - pos);
    end else if (pos < POS_W'(ODD_BASE)) begin
      s.lit = (scan_on && pos == scan_pos) ? scan_val : 8'h00;
    end else if (pos < POS_W'(BORDER)) begin
      s.sel = eplff_pkg::SEL_ODD;
      s.idx = IDX_W'(pos - POS_W'(ODD_BASE));
    end else if (pos >= POS_W'(TAIL_BASE)) begin
      s.lit = eplff_pkg::tail_byte(2'(pos - POS_W'(TAIL_BASE)));
    end
    return s;
  endfunction

  function automatic logic [7:0] form(input slot_t s, input logic [7:0] rd);
    logic [7:0] b;
    case (s.sel)
      eplff_pkg::SEL_EVEN: b = eplff_pkg::even_form(rd);
      eplff_pkg::SEL_ODD:  b = eplff_pkg::odd_form(rd);
      default:             b = s.lit;
    endcase
    return b;
  endfunction

  eplff_pkg::state_t state;
  eplff_pkg::state_t state_next;

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd0;
  logic [7:0]        rd1;

  logic [PAIR_W-1:0] k;
  logic              cur_bank;
  logic              cur_scan_on;
  logic [POS_W-1:0]  cur_scan_pos;
  logic [7:0]        cur_scan_val;

  logic              s1_valid;
  slot_t             s1_slot0;
  slot_t             s1_slot1;
  logic              s1_fs;
  logic              s1_last;

  slot_t             slot0;
  slot_t             slot1;
  logic              out_free;
  logic              s1_ready;
  logic              issue;
  logic              at_last;

  assign slot0 = classify({k, 1'b0}, cur_scan_on, cur_scan_pos, cur_scan_val);
  assign slot1 = classify({k, 1'b1}, cur_scan_on, cur_scan_pos, cur_scan_val);

  assign out_free = ~pair_valid | ~pair_stall;
  assign s1_ready = ~s1_valid | out_free;
  assign at_last  = (k == PAIR_W'(PAIRS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      eplff_pkg::ST_IDLE: begin
        if (job_valid) begin
          state_next = eplff_pkg::ST_RUN;
        end
      end
      eplff_pkg::ST_RUN: begin
        if (s1_ready && at_last) begin
          state_next = eplff_pkg::ST_IDLE;
        end
      end
      default: state_next = eplff_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop = 1'b0;
    issue   = 1'b0;
    unique case (state)
      eplff_pkg::ST_IDLE: job_pop = job_valid;
      eplff_pkg::ST_RUN:  issue   = s1_ready;
      default: ;
    endcase
  end

  // bank is released once its last pair is issued; no reads remain after that
  assign done      = issue & at_last;
  assign done_bank = cur_bank;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd0 <= mem[{cur_bank, slot0.idx}];
      rd1 <= mem[{cur_bank, slot1.idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= eplff_pkg::ST_IDLE;
      s1_valid   <= 1'b0;
      pair_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (s1_ready) begin
        s1_valid <= issue;
      end
      if (out_free) begin
        pair_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      k            <= '0;
      cur_bank     <= job.bank;
      cur_scan_on  <= job.scan_on;
      cur_scan_pos <= POS_W'(SCAN_BASE) + POS_W'(job.scan_at);
      cur_scan_val <= job.scan_val;
    end else if (issue) begin
      k <= k + PAIR_W'(1);
    end
    if (issue) begin
      s1_slot0 <= slot0;
      s1_slot1 <= slot1;
      s1_fs    <= (k < PAIR_W'(4)) || (k >= PAIR_W'(PAIRS - 2));
      s1_last  <= at_last;
    end
    if (out_free) begin
      pair.first_byte  <= form(s1_slot0, rd0);
      pair.second_byte <= form(s1_slot1, rd1);
      pair.frame_start <= s1_fs;
      pair.last_pair   <= s1_last;
    end
  end

endmodule

// ----- src/epaper_line_frame_formatter_core.sv -----
// E-paper line formatter. Pixel bytes of a display line arrive one per
// transaction, index 0 first, with the line number taken from the last byte.
// Once the last byte is in, the SPI command stream for that line leaves as
// byte pairs: 2*BYTES_PER_LINE + (LINE_COUNT+3)/4 + 12 bytes, rounded up to
// whole pairs (43 pairs at the default sizes). Two line banks let the next
// line load while the previous one is streamed; input takes one byte per
// cycle until both banks are full. The stream side gives one pair per cycle
// while pair_stall is low, with an idle state between lines; the rate is set
// by the pair generator's two-port read of the line banks. Each pair is
// registered once in the read stage and again at the output.
module epaper_line_frame_formatter_core #(
  parameter int BYTES_PER_LINE = eplff_pkg::BYTES_PER_LINE_DEF,
  parameter int LINE_COUNT     = eplff_pkg::LINE_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pixel_valid,
  output logic            pixel_stall,
  input  eplff_pkg::in_t  pixel,
  output logic            pair_valid,
  input  logic            pair_stall,
  output eplff_pkg::out_t pair
);

  localparam int ADDR_W = $clog2(BYTES_PER_LINE) + 1;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              job_push;
  eplff_pkg::job_t   push_job;
  eplff_pkg::job_t   head_job;
  logic              job_pop;
  logic              job_valid;
  logic              queue_full;
  logic              done;
  logic              done_bank;

  eplff_front #(
    .BYTES_PER_LINE (BYTES_PER_LINE),
    .LINE_COUNT     (LINE_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .job_push    (job_push),
    .job         (push_job),
    .queue_full  (queue_full),
    .done        (done),
    .done_bank   (done_bank)
  );

  eplff_job_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (push_job),
    .pop       (job_pop),
    .head      (head_job),
    .not_empty (job_valid),
    .full      (queue_full)
  );

  eplff_back #(
    .BYTES_PER_LINE (BYTES_PER_LINE),
    .LINE_COUNT     (LINE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job        (head_job),
    .job_pop    (job_pop),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .done       (done),
    .done_bank  (done_bank),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .pair       (pair)
  );

endmodule

// ----- src/eplff_checker.sv -----
module eplff_checker (
  input logic            clk,
  input logic            rst,
  input logic            pixel_valid,
  input logic            pixel_stall,
  input eplff_pkg::in_t  pixel,
  input logic            pair_valid,
  input logic            pair_stall,
  input eplff_pkg::out_t pair
);

  // stalled input transaction holds
  a_pixel_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
    else $error("pixel changed while stalled");

  // stalled pair holds
  a_pair_hold: assert property (@(posedge clk) disable iff (rst)
    pair_valid && pair_stall |=> pair_valid && $stable(pair))
    else $error("pair changed while stalled");

  a_last_is_tail: assert property (@(posedge clk) disable iff (rst)
    pair_valid && pair.last_pair |->
      pair.first_byte == eplff_pkg::CMD_DATA &&
      pair.second_byte == eplff_pkg::VAL_OUTPUT)
    else $error("last pair is not the output register write");

  a_last_framed: assert property (@(posedge clk) disable iff (rst)
    pair_valid && pair.last_pair |-> pair.frame_start)
    else $error("last pair without chip select pulse");

  a_framed_cmd: assert property (@(posedge clk) disable iff (rst)
    pair_valid && pair.frame_start |->
      pair.first_byte == eplff_pkg::CMD_INDEX ||
      pair.first_byte == eplff_pkg::CMD_DATA)
    else $error("chip select pulse before a non-command byte");

endmodule

bind epaper_line_frame_formatter_core eplff_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .pixel       (pixel),
  .pair_valid  (pair_valid),
  .pair_stall  (pair_stall),
  .pair        (pair)
);
